### src/sv32tlb_pkg.sv
package sv32tlb_pkg;

	// Table size and the fixed field widths of the request and result items.
	localparam int ENTRIES = 32;
	localparam int IDX_W   = 6;
	localparam int VPN_W   = 20;
	localparam int ASID_W  = 9;
	localparam int PPN_W   = 22;
	localparam int FLAGS_W = 8;
	localparam int CMD_W   = 2;
	localparam int VPN0_W  = 10;

	// Configuration port geometry.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register indexes, taken from paddr[2].
	localparam logic REG_TRANSLATE = 1'b0;

	// Command codes. Code 3 has no effect on the table.
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REFILL = 2'd2;

	// Request fields broadcast to every cell while a sweep runs.
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [VPN_W-1:0]  vpn;
		logic [ASID_W-1:0] asid;
	} req_t;

	// Sweep token handed from cell to cell, one hop per cycle.
	typedef struct packed {
		logic               active;
		logic               found;
		logic               multi;
		logic [IDX_W-1:0]   idx;
		logic [PPN_W-1:0]   ppn;
		logic               mega;
		logic [FLAGS_W-1:0] flags;
		logic               inv_found;
		logic [IDX_W-1:0]   inv_idx;
	} tok_t;

	// Entry write from the refill logic.
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [VPN_W-1:0]   vpn;
		logic [ASID_W-1:0]  asid;
		logic [PPN_W-1:0]   ppn;
		logic               mega;
		logic [FLAGS_W-1:0] flags;
		logic               valid;
	} wr_t;

endpackage

### src/sv32tlb_cell.sv
module sv32tlb_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [sv32tlb_pkg::IDX_W-1:0]  cell_idx,
	input  sv32tlb_pkg::req_t              req,
	input  sv32tlb_pkg::wr_t               wr,
	input  sv32tlb_pkg::tok_t              tok_in,
	output sv32tlb_pkg::tok_t              tok_out
);

	logic                               valid_q;
	logic [sv32tlb_pkg::VPN_W-1:0]      vpn_q;
	logic [sv32tlb_pkg::ASID_W-1:0]     asid_q;
	logic [sv32tlb_pkg::PPN_W-1:0]      ppn_q;
	logic                               mega_q;
	logic [sv32tlb_pkg::FLAGS_W-1:0]    flags_q;
	sv32tlb_pkg::tok_t                  tok_q;
	sv32tlb_pkg::tok_t                  tok_nxt;
	logic                               asid_eq;
	logic                               page_eq;
	logic                               hit_here;
	logic                               flush_here;
	logic                               wr_here;

	// Tag compare: a megapage ignores vpn0.
	assign asid_eq   = (asid_q == req.asid);
	assign page_eq   = (vpn_q[sv32tlb_pkg::VPN_W-1:sv32tlb_pkg::VPN0_W]
			== req.vpn[sv32tlb_pkg::VPN_W-1:sv32tlb_pkg::VPN0_W])
			&& (mega_q || (vpn_q[sv32tlb_pkg::VPN0_W-1:0]
			== req.vpn[sv32tlb_pkg::VPN0_W-1:0]));
	assign hit_here  = valid_q && asid_eq && page_eq;

	// A zero ASID or VPN in a flush acts as a wildcard.
	assign flush_here = tok_in.active && (req.cmd == sv32tlb_pkg::CMD_FLUSH) && valid_q
			&& ((req.asid == '0) || asid_eq) && ((req.vpn == '0) || page_eq);

	assign wr_here = wr.en && (wr.idx == cell_idx);

	// Fold this entry into the passing token.
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.active && (req.cmd == sv32tlb_pkg::CMD_LOOKUP) && hit_here) begin
			if (tok_in.found) begin
				tok_nxt.multi = 1'b1;
			end else begin
				tok_nxt.found = 1'b1;
				tok_nxt.idx   = cell_idx;
				tok_nxt.ppn   = ppn_q;
				tok_nxt.mega  = mega_q;
				tok_nxt.flags = flags_q;
			end
		end
		if (!valid_q && !tok_in.inv_found) begin
			tok_nxt.inv_found = 1'b1;
			tok_nxt.inv_idx   = cell_idx;
		end
	end

	// Token stage toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	// Entry valid bit: refill writes it, a matching flush clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_here) begin
			valid_q <= wr.valid;
		end else if (flush_here) begin
			valid_q <= 1'b0;
		end
	end

	// Entry payload.
	always_ff @(posedge clk) begin
		if (wr_here) begin
			vpn_q   <= wr.vpn;
			asid_q  <= wr.asid;
			ppn_q   <= wr.ppn;
			mega_q  <= wr.mega;
			flags_q <= wr.flags;
		end
	end

	assign tok_out = tok_q;

endmodule

### src/sv32tlb_table_engine_core.sv
// Sv32 fully associative TLB built as a chain of entry cells.
// Input channel: in_valid/in_stall with command, vpn, asid, ppn, megapage,
// pte_flags and entry_valid. Output channel: out_valid/out_stall with hit,
// multi_hit, entry_index, ptag, hit_megapage and hit_flags. Every item
// (lookup, flush, refill, or the unused command code) gives one result item.
// An accepted item launches a token that visits one entry cell per cycle,
// so the sweep covers all ENTRIES cells. At the end of the sweep the result
// is captured in a holding register and then moves to the output register.
// The next item can be accepted once the result has moved into the output
// register; no new item is taken while the last one is in flight. While
// the receiver stalls, the result holds on the output and a finished sweep
// waits in the holding register; in_stall stays high until that holding
// register drains. translate_enable lives at APB byte address 0 and must
// be written by the user only while the block is idle; the block does not
// enforce this. Reset clears every entry valid bit, the victim pointer,
// translate_enable and all handshake state; no clearing pass is needed.
module sv32_tlb_table_engine_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sv32tlb_pkg::ADDR_W-1:0]      paddr,
	input  logic [sv32tlb_pkg::DATA_W-1:0]      pwdata,
	output logic [sv32tlb_pkg::DATA_W-1:0]      prdata,
	output logic                                pready,
	// Request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sv32tlb_pkg::CMD_W-1:0]       command,
	input  logic [sv32tlb_pkg::VPN_W-1:0]       vpn,
	input  logic [sv32tlb_pkg::ASID_W-1:0]      asid,
	input  logic [sv32tlb_pkg::PPN_W-1:0]       ppn,
	input  logic                                megapage,
	input  logic [sv32tlb_pkg::FLAGS_W-1:0]     pte_flags,
	input  logic                                entry_valid,
	// Result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic                                multi_hit,
	output logic [sv32tlb_pkg::IDX_W-1:0]       entry_index,
	output logic [sv32tlb_pkg::PPN_W-1:0]       ptag,
	output logic                                hit_megapage,
	output logic [sv32tlb_pkg::FLAGS_W-1:0]     hit_flags
);

	logic                                translate_q;
	logic                                busy_q;
	logic                                start_q;
	logic                                pend_valid_q;
	logic                                out_valid_q;
	sv32tlb_pkg::req_t                   req_q;
	logic [sv32tlb_pkg::PPN_W-1:0]       req_ppn_q;
	logic                                req_mega_q;
	logic [sv32tlb_pkg::FLAGS_W-1:0]     req_flags_q;
	logic                                req_evalid_q;
	logic [sv32tlb_pkg::IDX_W-1:0]       victim_q;
	sv32tlb_pkg::tok_t                   tok [sv32tlb_pkg::ENTRIES+1];
	sv32tlb_pkg::tok_t                   tok_last;
	sv32tlb_pkg::wr_t                    wr;
	logic [sv32tlb_pkg::ENTRIES:0]       tok_active;
	logic                                in_accept;
	logic                                cfg_write;
	logic                                sweep_done;
	logic                                pend_move;
	logic [sv32tlb_pkg::IDX_W-1:0]       refill_idx;

	// Result fields of the holding and output registers.
	logic                                res_hit,   pend_hit_q,   out_hit_q;
	logic                                res_multi, pend_multi_q, out_multi_q;
	logic [sv32tlb_pkg::IDX_W-1:0]       res_idx,   pend_idx_q,   out_idx_q;
	logic [sv32tlb_pkg::PPN_W-1:0]       res_ptag,  pend_ptag_q,  out_ptag_q;
	logic                                res_mega,  pend_mega_q,  out_mega_q;
	logic [sv32tlb_pkg::FLAGS_W-1:0]     res_flags, pend_flags_q, out_flags_q;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			translate_q <= 1'b0;
		end else if (cfg_write && (paddr[2] == sv32tlb_pkg::REG_TRANSLATE)) begin
			translate_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			sv32tlb_pkg::REG_TRANSLATE: prdata[0] = translate_q;
			default:                    prdata    = '0;
		endcase
	end

	// Request capture. One item is in the block at a time.
	assign in_stall  = busy_q;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q.cmd    <= command;
			req_q.vpn    <= vpn;
			req_q.asid   <= asid;
			req_ppn_q    <= ppn;
			req_mega_q   <= megapage;
			req_flags_q  <= pte_flags;
			req_evalid_q <= entry_valid;
		end
	end

	// Token launch into the first cell.
	always_comb begin
		tok[0]        = '0;
		tok[0].active = start_q;
	end

	// The chain of entry cells.
	for (genvar i = 0; i < sv32tlb_pkg::ENTRIES; i++) begin : g_cell
		sv32tlb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (sv32tlb_pkg::IDX_W'(i)),
			.req      (req_q),
			.wr       (wr),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	for (genvar i = 0; i <= sv32tlb_pkg::ENTRIES; i++) begin : g_act
		assign tok_active[i] = tok[i].active;
	end

	assign tok_last   = tok[sv32tlb_pkg::ENTRIES];
	assign sweep_done = tok_last.active;

	// Refill goes to the first invalid entry, else to the victim pointer.
	assign refill_idx = tok_last.inv_found ? tok_last.inv_idx : victim_q;

	always_comb begin
		wr       = '0;
		wr.en    = sweep_done && (req_q.cmd == sv32tlb_pkg::CMD_REFILL);
		wr.idx   = refill_idx;
		wr.vpn   = req_q.vpn;
		wr.asid  = req_q.asid;
		wr.ppn   = req_ppn_q;
		wr.mega  = req_mega_q;
		wr.flags = req_flags_q;
		wr.valid = req_evalid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			victim_q <= '0;
		end else if (wr.en) begin
			victim_q <= (refill_idx == sv32tlb_pkg::IDX_W'(sv32tlb_pkg::ENTRIES - 1))
					? '0 : refill_idx + 1'b1;
		end
	end

	// Result assembly at the end of the sweep.
	always_comb begin
		res_hit   = 1'b0;
		res_multi = 1'b0;
		res_idx   = '0;
		res_ptag  = '0;
		res_mega  = 1'b0;
		res_flags = '0;
		case (req_q.cmd)
			sv32tlb_pkg::CMD_LOOKUP: begin
				if (!translate_q) begin
					res_hit  = 1'b1;
					res_ptag = sv32tlb_pkg::PPN_W'(req_q.vpn);
				end else begin
					res_hit   = tok_last.found;
					res_multi = tok_last.multi;
					res_idx   = tok_last.idx;
					res_mega  = tok_last.mega;
					res_flags = tok_last.flags;
					res_ptag  = tok_last.mega
							? {tok_last.ppn[sv32tlb_pkg::PPN_W-1:sv32tlb_pkg::VPN0_W],
							   req_q.vpn[sv32tlb_pkg::VPN0_W-1:0]}
							: tok_last.ppn;
				end
			end
			sv32tlb_pkg::CMD_REFILL: begin
				res_idx = refill_idx;
			end
			default: begin
				res_hit = 1'b0;
			end
		endcase
	end

	// Control: busy from accept until the result leaves the holding register.
	assign pend_move = pend_valid_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			start_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			start_q <= in_accept;
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (pend_move) begin
				busy_q <= 1'b0;
			end
			if (sweep_done) begin
				pend_valid_q <= 1'b1;
			end else if (pend_move) begin
				pend_valid_q <= 1'b0;
			end
			if (pend_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Holding and output payload registers.
	always_ff @(posedge clk) begin
		if (sweep_done) begin
			pend_hit_q   <= res_hit;
			pend_multi_q <= res_multi;
			pend_idx_q   <= res_idx;
			pend_ptag_q  <= res_ptag;
			pend_mega_q  <= res_mega;
			pend_flags_q <= res_flags;
		end
		if (pend_move) begin
			out_hit_q   <= pend_hit_q;
			out_multi_q <= pend_multi_q;
			out_idx_q   <= pend_idx_q;
			out_ptag_q  <= pend_ptag_q;
			out_mega_q  <= pend_mega_q;
			out_flags_q <= pend_flags_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = out_hit_q;
	assign multi_hit    = out_multi_q;
	assign entry_index  = out_idx_q;
	assign ptag         = out_ptag_q;
	assign hit_megapage = out_mega_q;
	assign hit_flags    = out_flags_q;

	// At most one token travels the chain at any time.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_active))
		else $error("more than one sweep token in the cell chain");

	// A token in the chain always belongs to an accepted item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(tok_active != '0) |-> busy_q)
		else $error("sweep token present while block is idle");

	// A waiting result always belongs to an accepted item.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> busy_q && !start_q)
		else $error("holding register full outside a sweep");

	// An accepted item launches a token on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> start_q && !pend_valid_q)
		else $error("accepted item did not start a sweep");

endmodule
